// ===== src/dq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg: shared types and constants for the double-ended queue
// Operation and status codes, default sizes and the per-chain cell command.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int VALUE_W        = 32;

  typedef enum logic [2:0] {
    ACT_PUSH_BACK  = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_POP_BACK   = 3'd2,
    ACT_POP_FRONT  = 3'd3,
    ACT_CLEAR      = 3'd4,
    ACT_PEEK       = 3'd5
  } dq_action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } dq_status_t;

  // shift_in:  push at this chain's head end
  // shift_out: pop at this chain's head end
  // append:    push at the far end, into the cell at the current count
  typedef struct packed {
    logic shift_in;
    logic shift_out;
    logic append;
  } dq_cmd_t;

endpackage

// ===== src/dq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_cell: one storage cell of a deque chain
// Holds one element; takes its left neighbor, right neighbor or the pushed item.
// ----------------------------------------------------------------------------
module dq_cell
  import dq_pkg::*;
#(
  parameter int INDEX      = 0,
  parameter int CNT_W      = 5,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  dq_cmd_t               cmd,
  input  logic [CNT_W-1:0]      count,
  input  logic [DATA_WIDTH-1:0] push_data,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  output logic [DATA_WIDTH-1:0] data
);

  logic [DATA_WIDTH-1:0] data_next;

  always_comb begin
    data_next = data;
    if (cmd.shift_in) begin
      data_next = left_data;
    end else if (cmd.shift_out) begin
      data_next = right_data;
    end else if (cmd.append && (count == CNT_W'(INDEX))) begin
      data_next = push_data;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

// ===== src/dq_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_chain: row of deque cells seen from one end
// Cell 0 holds the element at this chain's end; neighbors pass data each shift.
// ----------------------------------------------------------------------------
module dq_chain
  import dq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int CNT_W      = 5,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  dq_cmd_t               cmd,
  input  logic [CNT_W-1:0]      count,
  input  logic [DATA_WIDTH-1:0] push_data,
  output logic [DATA_WIDTH-1:0] head_data
);

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_in;
    logic [DATA_WIDTH-1:0] right_in;

    if (i == 0) begin : g_first
      assign left_in = push_data;
    end else begin : g_mid_l
      assign left_in = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_in = cell_data[i];
    end else begin : g_mid_r
      assign right_in = cell_data[i+1];
    end

    dq_cell #(
      .INDEX      (i),
      .CNT_W      (CNT_W),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .count      (count),
      .push_data  (push_data),
      .left_data  (left_in),
      .right_data (right_in),
      .data       (cell_data[i])
    );
  end

  assign head_data = cell_data[0];

endmodule

// ===== src/double_ended_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque of DEPTH elements
// Push and pop at either end, clear and peek, one result item per input item.
// ----------------------------------------------------------------------------
// Each accepted item is executed and its result appears in the output
// register on the next cycle, so the block sustains one item per clock while
// out_stall is low; a new item is taken whenever the output register is empty
// or being drained. The elements live in two mirrored chains of DEPTH cells,
// one with the front element in its first cell and one with the back element
// in its first cell, so both ends are read from fixed cells and every push or
// pop is a shift or local write. A pop on an empty deque reports status 1, a
// push on a full deque reports status 2; neither changes the contents.
// ----------------------------------------------------------------------------
module double_ended_queue
  import dq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int CNT_W     = $clog2(DEPTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [2:0]                action,
  input  logic signed [VALUE_W-1:0] push_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [VALUE_W-1:0] front_value,
  output logic signed [VALUE_W-1:0] back_value,
  output logic [CNT_W-1:0]          fill_count,
  output logic                      is_empty,
  output logic [1:0]                status
);

  logic [CNT_W-1:0]             count;
  logic [CNT_W-1:0]             count_next;
  dq_status_t                   status_next;
  dq_cmd_t                      front_cmd;
  dq_cmd_t                      back_cmd;
  logic                         accept;
  logic                         full;
  logic                         empty;
  logic [DATA_WIDTH-1:0]        push_data;
  logic signed [DATA_WIDTH-1:0] front_data;
  logic signed [DATA_WIDTH-1:0] back_data;

  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;
  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign push_data = DATA_WIDTH'(push_value);

  always_comb begin
    count_next  = count;
    status_next = ST_OK;
    front_cmd   = '0;
    back_cmd    = '0;
    case (action)
      ACT_PUSH_BACK: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          front_cmd.append  = 1'b1;
          back_cmd.shift_in = 1'b1;
          count_next        = count + 1'b1;
        end
      end
      ACT_PUSH_FRONT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          front_cmd.shift_in = 1'b1;
          back_cmd.append    = 1'b1;
          count_next         = count + 1'b1;
        end
      end
      ACT_POP_BACK: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          back_cmd.shift_out = 1'b1;
          count_next         = count - 1'b1;
        end
      end
      ACT_POP_FRONT: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          front_cmd.shift_out = 1'b1;
          count_next          = count - 1'b1;
        end
      end
      ACT_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
    if (!accept) begin
      front_cmd = '0;
      back_cmd  = '0;
    end
  end

  dq_chain #(
    .DEPTH      (DEPTH),
    .CNT_W      (CNT_W),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front_chain (
    .clk       (clk),
    .cmd       (front_cmd),
    .count     (count),
    .push_data (push_data),
    .head_data (front_data)
  );

  dq_chain #(
    .DEPTH      (DEPTH),
    .CNT_W      (CNT_W),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back_chain (
    .clk       (clk),
    .cmd       (back_cmd),
    .count     (count),
    .push_data (push_data),
    .head_data (back_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
      status    <= ST_OK;
    end else begin
      if (accept) begin
        count     <= count_next;
        status    <= status_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign fill_count  = count;
  assign is_empty    = empty;
  assign front_value = empty ? '0 : VALUE_W'(front_data);
  assign back_value  = empty ? '0 : VALUE_W'(back_data);

endmodule
